// ----- design/ewrms_pkg.sv -----
// Shared types and constants for the per-channel EWMA RMS tracker.
package ewrms_pkg;

	localparam int MAX_CHANNELS = 32;
	localparam int CH_W         = 5;
	localparam int RMS_W        = 24;
	localparam int CFG_IDX_W    = 2;
	localparam int QDEPTH       = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHAN_EN = 2'd1;

	localparam logic [31:0] ALPHA_RESET   = 32'd143166;
	localparam logic [31:0] CHAN_EN_RESET = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [CH_W-1:0]    channel;
		logic signed [15:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [CH_W-1:0]  channel_out;
		logic [RMS_W-1:0] rms;
		logic             processed;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [CH_W-1:0] channel;
		logic            active;
		logic            first;
		logic [31:0]     target_hi;
	} q_entry_t;

endpackage

// ----- design/ewrms_front.sv -----
// Front end: accepts samples, checks enable, squares the sample, tracks first samples.
module ewrms_front #(
	parameter int NUM_CHANNELS = 32,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ewrms_pkg::in_item_t in_data,
	input  logic [31:0]         chan_en,
	output logic                push,
	output ewrms_pkg::q_entry_t push_data,
	input  logic                q_full
);

	localparam int NCH   = (NUM_CHANNELS < ewrms_pkg::MAX_CHANNELS) ?
		NUM_CHANNELS : ewrms_pkg::MAX_CHANNELS;
	localparam int IDX_W = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int SX    = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
	localparam int SQ_W  = 2 * SAMPLE_BITS;

	logic [NCH-1:0]         first_q;
	logic [SX-1:0]          sample_ext;
	logic [SAMPLE_BITS-1:0] raw;
	logic [SAMPLE_BITS-1:0] mag;
	logic [SQ_W-1:0]        sq;
	logic [63:0]            sq64;
	logic [IDX_W-1:0]       idx;
	logic                   in_range;
	logic                   active;
	logic                   accept;

	assign in_ready   = !q_full;
	assign accept     = in_valid && in_ready;
	assign sample_ext = SX'($unsigned(in_data.sample));
	assign raw        = sample_ext[SAMPLE_BITS-1:0];
	assign mag        = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
	assign sq         = SQ_W'(mag) * SQ_W'(mag);
	assign sq64       = 64'(sq);
	assign idx        = in_data.channel[IDX_W-1:0];
	assign in_range   = 6'(in_data.channel) < 6'(NCH);
	assign active     = in_range && chan_en[in_data.channel];

	always_comb begin
		push_data.channel = in_data.channel;
		push_data.active  = active;
		push_data.first   = active && first_q[idx];
		if (sq64[63:32] != 32'd0) begin
			push_data.target_hi = 32'hFFFF_FFFF;
		end else begin
			push_data.target_hi = sq64[31:0];
		end
	end

	assign push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= '1;
		end else if (accept && active) begin
			first_q[idx] <= 1'b0;
		end
	end

endmodule

// ----- design/ewrms_queue.sv -----
// Short FIFO between front and back end.
module ewrms_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  ewrms_pkg::q_entry_t push_data,
	output logic                full,
	input  logic                pop,
	output logic                head_valid,
	output ewrms_pkg::q_entry_t head
);

	localparam int DEPTH = ewrms_pkg::QDEPTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	ewrms_pkg::q_entry_t slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count beyond depth");

endmodule

// ----- design/ewrms_back.sv -----
// Back end: mean update through the per-channel memory and iterative square root.
module ewrms_back #(
	parameter int NUM_CHANNELS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  ewrms_pkg::q_entry_t  head,
	output logic                 pop,
	input  logic [31:0]          alpha,
	output logic                 out_valid,
	input  logic                 out_ready,
	output ewrms_pkg::out_item_t out_data
);

	localparam int NCH   = (NUM_CHANNELS < ewrms_pkg::MAX_CHANNELS) ?
		NUM_CHANNELS : ewrms_pkg::MAX_CHANNELS;
	localparam int IDX_W = (NCH > 1) ? $clog2(NCH) : 1;
	localparam int RW    = ewrms_pkg::RMS_W;
	localparam int BW    = $clog2(RW);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIFF = 4'd1;
	localparam logic [3:0] ST_MLO  = 4'd2;
	localparam logic [3:0] ST_MHI  = 4'd3;
	localparam logic [3:0] ST_STEP = 4'd4;
	localparam logic [3:0] ST_WR   = 4'd5;
	localparam logic [3:0] ST_SQRT = 4'd6;
	localparam logic [3:0] ST_OUT  = 4'd7;

	logic [63:0] mem [NCH];
	logic [63:0] rd_q;

	logic [3:0]                     state_q;
	logic [ewrms_pkg::CH_W-1:0]     ch_q;
	logic                           proc_q;
	logic [31:0]                    tgt_q;
	logic [63:0]                    mean_q;
	logic [63:0]                    diff_q;
	logic                           ge_q;
	logic [63:0]                    plo_q;
	logic [63:0]                    phi_q;
	logic [63:0]                    step_q;
	logic [47:0]                    v_q;
	logic [RW-1:0]                  root_q;
	logic [BW-1:0]                  bit_q;
	logic                           out_valid_q;
	ewrms_pkg::out_item_t           out_q;

	logic [63:0]    target;
	logic [63:0]    mean_new;
	logic [RW-1:0]  trial;
	logic [47:0]    trial_sq;
	logic [RW-1:0]  root_next;
	logic           out_free;
	logic [IDX_W-1:0] head_idx;
	logic [IDX_W-1:0] cur_idx;

	assign target    = {tgt_q, 32'd0};
	assign mean_new  = ge_q ? (mean_q + step_q) : (mean_q - step_q);
	assign trial     = root_q | (RW'(1) << bit_q);
	assign trial_sq  = 48'(trial) * 48'(trial);
	assign root_next = (trial_sq <= v_q) ? trial : root_q;
	assign out_free  = !out_valid_q || out_ready;
	assign head_idx  = head.channel[IDX_W-1:0];
	assign cur_idx   = ch_q[IDX_W-1:0];
	assign pop       = (state_q == ST_IDLE) && head_valid;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			rd_q <= mem[head_idx];
		end
		if (state_q == ST_WR) begin
			mem[cur_idx] <= mean_new;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ch_q   <= head.channel;
				proc_q <= head.active;
				tgt_q  <= head.target_hi;
				root_q <= '0;
				mean_q <= {head.target_hi, 32'd0};
				step_q <= '0;
				ge_q   <= 1'b1;
			end
			ST_DIFF: begin
				mean_q <= rd_q;
				ge_q   <= target >= rd_q;
				diff_q <= (target >= rd_q) ? (target - rd_q) : (rd_q - target);
			end
			ST_MLO: plo_q <= 64'(diff_q[31:0]) * 64'(alpha);
			ST_MHI: phi_q <= 64'(diff_q[63:32]) * 64'(alpha);
			ST_STEP: step_q <= phi_q + {32'd0, plo_q[63:32]};
			ST_WR: begin
				v_q    <= mean_new[63:16];
				root_q <= '0;
				bit_q  <= BW'(RW - 1);
			end
			ST_SQRT: begin
				root_q <= root_next;
				bit_q  <= bit_q - 1'b1;
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						if (!head.active) begin
							state_q <= ST_OUT;
						end else if (head.first) begin
							state_q <= ST_WR;
						end else begin
							state_q <= ST_DIFF;
						end
					end
				end
				ST_DIFF: state_q <= ST_MLO;
				ST_MLO:  state_q <= ST_MHI;
				ST_MHI:  state_q <= ST_STEP;
				ST_STEP: state_q <= ST_WR;
				ST_WR:   state_q <= ST_SQRT;
				ST_SQRT: begin
					if (bit_q == '0) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_q.channel_out <= ch_q;
			out_q.rms         <= root_q;
			out_q.processed   <= proc_q;
		end
	end

	a_idle_rms_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.processed |-> out_q.rms == '0)
		else $error("unprocessed result carries nonzero rms");

	a_wr_to_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WR |=> state_q == ST_SQRT)
		else $error("mean write not followed by root iteration");

	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SQRT |-> 48'(root_q) * 48'(root_q) <= v_q)
		else $error("partial root exceeds radicand");

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == ST_IDLE)
		else $error("queue popped while busy");

endmodule

// ----- design/ewma_rms_tracker_unit.sv -----
// Top level of the per-channel exponentially weighted RMS tracker.
//
//   channel  signals                               direction  payload
//   in       in_valid, in_ready, in_data           sink       ewrms_pkg::in_item_t
//   out      out_valid, out_ready, out_data        source     ewrms_pkg::out_item_t
//   cfg      cfg_valid, cfg_ready, cfg_index/data  sink       register index, 32-bit data
//
// Enabled sample in the back end: memory read, two 32x32 partial products,
// mean write, 24 root iterations; the first sample of a channel skips the
// difference and products. Disabled or out-of-range channel: straight to output.
// The back end works one item at a time; a two-entry queue lets the front
// keep taking transfers meanwhile. Reset sets alpha and the enable mask to defaults
// and marks every channel as awaiting its first sample. cfg_ready is always high.
module ewma_rms_tracker_unit #(
	parameter int NUM_CHANNELS = 32,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  ewrms_pkg::in_item_t                 in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output ewrms_pkg::out_item_t                out_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [ewrms_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                         cfg_data
);

	logic [31:0]         alpha_q;
	logic [31:0]         chan_en_q;
	logic                push;
	ewrms_pkg::q_entry_t push_data;
	logic                q_full;
	logic                pop;
	logic                head_valid;
	ewrms_pkg::q_entry_t head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q   <= ewrms_pkg::ALPHA_RESET;
			chan_en_q <= ewrms_pkg::CHAN_EN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ewrms_pkg::REG_ALPHA:   alpha_q   <= cfg_data;
				ewrms_pkg::REG_CHAN_EN: chan_en_q <= cfg_data;
				default: ;
			endcase
		end
	end

	ewrms_front #(
		.NUM_CHANNELS(NUM_CHANNELS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.chan_en  (chan_en_q),
		.push     (push),
		.push_data(push_data),
		.q_full   (q_full)
	);

	ewrms_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	ewrms_back #(
		.NUM_CHANNELS(NUM_CHANNELS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.alpha     (alpha_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ----- verif/ewma_rms_tracker_unit_tb.sv -----
// Testbench for the per-channel EWMA RMS tracker: queued stimulus, a scoreboard, random stalls.
module ewma_rms_tracker_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int TAIL_CYCLES = 64;
	localparam int SQUEEZE_LEN = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                                 in_valid = 1'b0;
	logic                                 in_ready;
	ewrms_pkg::in_item_t                  in_data = '0;
	logic                                 out_valid;
	logic                                 out_ready = 1'b0;
	ewrms_pkg::out_item_t                 out_data;
	logic                                 cfg_valid = 1'b0;
	logic                                 cfg_ready;
	logic [ewrms_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [31:0]                          cfg_data = '0;

	ewma_rms_tracker_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	// shadow of the block's registers and per-channel state
	logic [31:0] alpha_sh;
	logic [31:0] chan_en_sh;
	logic [63:0] mean_sh [ewrms_pkg::MAX_CHANNELS];
	logic        fresh_sh [ewrms_pkg::MAX_CHANNELS];

	ewrms_pkg::in_item_t  sample_q [$];
	ewrms_pkg::out_item_t rms_expect_q [$];
	ewrms_pkg::out_item_t want;

	int  err_cnt = 0;
	int  cycle_cnt = 0;
	int  gap_cnt = 0;
	int  hold_cnt = 0;
	bit  no_idle = 1'b0;
	bit  squeeze_req = 1'b0;
	bit  squeeze_done = 1'b0;

	function automatic logic [23:0] root24(input logic [63:0] v);
		logic [63:0] root;
		logic [63:0] t;
		int b;
		root = '0;
		for (b = 23; b >= 0; b--) begin
			t = root | (64'd1 << b);
			if (t * t <= v)
				root = t;
		end
		return root[23:0];
	endfunction

	function automatic logic [63:0] weigh(input logic [63:0] diff);
		logic [95:0] prod;
		prod = {32'd0, diff} * {64'd0, alpha_sh};
		return prod[95:32];
	endfunction

	function automatic ewrms_pkg::out_item_t rms_predict(input ewrms_pkg::in_item_t it);
		ewrms_pkg::out_item_t r;
		int          s;
		int          c;
		logic [31:0] mag;
		logic [31:0] sq;
		logic [63:0] target;
		logic [63:0] m;
		c = it.channel;
		r.channel_out = it.channel;
		r.rms = '0;
		r.processed = 1'b0;
		if (!chan_en_sh[c])
			return r;
		s = it.sample;
		mag = (s < 0) ? -s : s;
		sq = mag * mag;
		target = {sq, 32'd0};
		if (fresh_sh[c]) begin
			m = target;
			fresh_sh[c] = 1'b0;
		end else begin
			m = mean_sh[c];
			if (target >= m)
				m = m + weigh(target - m);
			else
				m = m - weigh(m - target);
		end
		mean_sh[c] = m;
		r.rms = root24(m >> 16);
		r.processed = 1'b1;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic signed [15:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return 16'($urandom_range(0, 16) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic flag_error(input string msg);
		err_cnt++;
		$display("ERROR %0t: %s", $time, msg);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data  <= '0;
			gap_cnt  <= 0;
		end else begin
			if (in_valid && in_ready)
				rms_expect_q.push_back(rms_predict(in_data));
			if (!in_valid || in_ready) begin
				if (gap_cnt > 0) begin
					gap_cnt  <= gap_cnt - 1;
					in_valid <= 1'b0;
				end else if (sample_q.size() > 0) begin
					in_valid <= 1'b1;
					in_data  <= sample_q.pop_front();
					gap_cnt  <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready    <= 1'b0;
			hold_cnt     <= 0;
			squeeze_done <= 1'b0;
		end else if (squeeze_req && !squeeze_done) begin
			out_ready    <= 1'b0;
			hold_cnt     <= SQUEEZE_LEN;
			squeeze_done <= 1'b1;
		end else if (hold_cnt > 0) begin
			out_ready <= 1'b0;
			hold_cnt  <= hold_cnt - 1;
		end else if ($urandom_range(0, 3) == 0 && !no_idle) begin
			out_ready <= 1'b0;
			hold_cnt  <= pick_gap();
		end else begin
			out_ready <= 1'b1;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (rms_expect_q.size() == 0) begin
				flag_error($sformatf("unexpected result ch %0d", out_data.channel_out));
			end else begin
				want = rms_expect_q.pop_front();
				if (out_data.channel_out !== want.channel_out)
					flag_error($sformatf("channel_out got %0d want %0d",
						out_data.channel_out, want.channel_out));
				if (out_data.rms !== want.rms)
					flag_error($sformatf("ch %0d rms got %0d want %0d",
						want.channel_out, out_data.rms, want.rms));
				if (out_data.processed !== want.processed)
					flag_error($sformatf("ch %0d processed got %0b want %0b",
						want.channel_out, out_data.processed, want.processed));
			end
		end
	end

	always @(posedge clk)
		cycle_cnt <= cycle_cnt + 1;

	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("ewma_rms_tracker_unit: mismatch");
		$finish;
	end

	task automatic add(input int ch, input logic signed [15:0] s);
		ewrms_pkg::in_item_t it;
		it.channel = ch[ewrms_pkg::CH_W-1:0];
		it.sample  = s;
		sample_q.push_back(it);
	endtask

	task automatic drain();
		while (sample_q.size() != 0 || in_valid || rms_expect_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic cfg_write(input logic [ewrms_pkg::CFG_IDX_W-1:0] idx,
		input logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
		if (idx == ewrms_pkg::REG_ALPHA)
			alpha_sh = val;
		else if (idx == ewrms_pkg::REG_CHAN_EN)
			chan_en_sh = val;
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int p;
		int k;
		int ch;
		logic [31:0] a;
		logic [31:0] e;
		alpha_sh   = ewrms_pkg::ALPHA_RESET;
		chan_en_sh = ewrms_pkg::CHAN_EN_RESET;
		for (k = 0; k < ewrms_pkg::MAX_CHANNELS; k++) begin
			fresh_sh[k] = 1'b1;
			mean_sh[k]  = '0;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// defaults: first samples, extremes, sign boundary
		add(0, 16'sd0);
		add(0, 16'sh7FFF);
		add(0, 16'sh8000);
		add(0, -16'sd1);
		add(31, 16'sh8000);
		add(31, 16'sh7FFF);
		add(31, 16'sd1);
		add(15, 16'sh5555);
		add(15, 16'shAAAA);
		drain();

		// full weight, most channels disabled
		cfg_write(ewrms_pkg::REG_ALPHA, 32'hFFFF_FFFF);
		cfg_write(ewrms_pkg::REG_CHAN_EN, 32'h8000_0001);
		add(0, 16'sd100);
		add(0, 16'sh8000);
		add(1, 16'sd123);
		add(31, 16'sd0);
		add(30, -16'sd5);
		drain();

		// zero weight freezes the mean
		cfg_write(ewrms_pkg::REG_ALPHA, 32'd0);
		cfg_write(ewrms_pkg::REG_CHAN_EN, 32'hFFFF_FFFF);
		add(0, 16'sd7);
		add(31, 16'sh8000);
		add(2, 16'sd1234);
		add(2, -16'sd1);
		drain();

		// everything disabled
		cfg_write(ewrms_pkg::REG_ALPHA, 32'd1);
		cfg_write(ewrms_pkg::REG_CHAN_EN, 32'd0);
		add(0, 16'sd1);
		add(31, -16'sd1);
		drain();

		for (p = 0; p < 8; p++) begin
			case (p % 5)
				0: a = ewrms_pkg::ALPHA_RESET;
				1: a = 32'hFFFF_FFFF;
				2: a = 32'd1;
				3: a = $urandom_range(1, 1 << 16);
				default: a = $urandom;
			endcase
			case (p % 4)
				0: e = 32'hFFFF_FFFF;
				1: e = $urandom;
				2: e = $urandom | $urandom;
				default: e = $urandom & $urandom;
			endcase
			if (a == 32'd0)
				a = 32'd1;
			cfg_write(ewrms_pkg::REG_ALPHA, a);
			cfg_write(ewrms_pkg::REG_CHAN_EN, e);
			no_idle     = (p == 2 || p == 5);
			squeeze_req = (p == 4);
			for (k = 0; k < 218; k++) begin
				if ($urandom_range(0, 3) == 0)
					ch = $urandom_range(0, 3);
				else
					ch = $urandom_range(0, ewrms_pkg::MAX_CHANNELS - 1);
				add(ch, pick_sample());
			end
			drain();
		end

		no_idle = 1'b0;
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_cnt == 0 && rms_expect_q.size() == 0)
			$display("ewma_rms_tracker_unit: match");
		else
			$display("ewma_rms_tracker_unit: mismatch");
		$finish;
	end

endmodule
